// ===== hw/rtl/sbra_pkg.sv =====
// ----------------------------------------------------------------------------
// sbra_pkg: shared types and constants of the sparse block row adder
// Field widths, command, status and register codes, and the saturating add.
// ----------------------------------------------------------------------------
package sbra_pkg;

   localparam int unsigned SBRA_MAX_COLUMNS    = 1024;
   localparam int unsigned SBRA_MAX_SLOTS      = 64;
   localparam int unsigned SBRA_MAX_BLOCK_EDGE = 4;
   localparam int unsigned SBRA_VALUE_WIDTH    = 32;
   localparam int unsigned SBRA_SLOT_ELEMS     = SBRA_MAX_BLOCK_EDGE * SBRA_MAX_BLOCK_EDGE;

   localparam int unsigned CMD_W       = 2;
   localparam int unsigned COL_W       = 10;
   localparam int unsigned ELEM_W      = 4;
   localparam int unsigned BNNZ_W      = ELEM_W + 1;
   localparam int unsigned STATUS_W    = 3;
   localparam int unsigned EDGE_W      = 3;
   localparam int unsigned COUNT_W     = 11;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 11;

   typedef enum logic [CMD_W-1:0] {
      CMD_ELEM_A = 2'd0,
      CMD_ELEM_B = 2'd1,
      CMD_READ   = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_ACCEPTED   = 3'd0,
      STAT_READ_DATA  = 3'd1,
      STAT_ROW_EMPTY  = 3'd2,
      STAT_SLOTS_FULL = 3'd3,
      STAT_BAD        = 3'd4
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_BLOCK_EDGE   = 2'd0,
      REG_COLUMN_COUNT = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_A    = 2'd0,
      PH_B    = 2'd1,
      PH_READ = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOKUP,
      S_MERGE,
      S_READ,
      S_RESULT
   } state_type;

   typedef struct packed {
      status_type                          status;
      logic [COL_W-1:0]                    column;
      logic [ELEM_W-1:0]                   element;
      logic signed [SBRA_VALUE_WIDTH-1:0]  value;
      logic                                last;
   } rsp_word_type;

   function automatic logic signed [SBRA_VALUE_WIDTH-1:0] sat_add(
      input logic signed [SBRA_VALUE_WIDTH-1:0] a,
      input logic signed [SBRA_VALUE_WIDTH-1:0] b
   );
      logic signed [SBRA_VALUE_WIDTH:0] sum;
      logic signed [SBRA_VALUE_WIDTH-1:0] res;
      sum = {a[SBRA_VALUE_WIDTH-1], a} + {b[SBRA_VALUE_WIDTH-1], b};
      if (sum[SBRA_VALUE_WIDTH] != sum[SBRA_VALUE_WIDTH-1]) begin
         res = sum[SBRA_VALUE_WIDTH] ? {1'b1, {(SBRA_VALUE_WIDTH-1){1'b0}}}
                                     : {1'b0, {(SBRA_VALUE_WIDTH-1){1'b1}}};
      end else begin
         res = sum[SBRA_VALUE_WIDTH-1:0];
      end
      return res;
   endfunction

endpackage

// ===== hw/rtl/sbra_if.sv =====
// ----------------------------------------------------------------------------
// sbra_if: channels of the sparse block row adder
// Request, response and register-write channels, each valid/ready.
// ----------------------------------------------------------------------------
interface sbra_req_if import sbra_pkg::*; ();
   logic                               valid;
   logic                               ready;
   logic [CMD_W-1:0]                   cmd;
   logic [COL_W-1:0]                   block_column;
   logic [ELEM_W-1:0]                  element_index;
   logic signed [SBRA_VALUE_WIDTH-1:0] element_value;

   modport source(output valid, cmd, block_column, element_index, element_value,
                  input ready);
   modport sink(input valid, cmd, block_column, element_index, element_value,
                output ready);
endinterface

interface sbra_rsp_if import sbra_pkg::*; ();
   logic                               valid;
   logic                               ready;
   logic [STATUS_W-1:0]                status;
   logic [COL_W-1:0]                   out_column;
   logic [ELEM_W-1:0]                  out_element;
   logic signed [SBRA_VALUE_WIDTH-1:0] out_value;
   logic                               row_last;

   modport source(output valid, status, out_column, out_element, out_value, row_last,
                  input ready);
   modport sink(input valid, status, out_column, out_element, out_value, row_last,
                output ready);
endinterface

interface sbra_csr_if import sbra_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/sparse_block_row_add.sv =====
// ----------------------------------------------------------------------------
// sparse_block_row_add: merge of one block row of two sparse matrices
// Words of A, then of B, are summed per block column; reads return the row.
// ----------------------------------------------------------------------------
// Usage
//   req_ch : one word per element of A (cmd 0) or B (cmd 1), or a read (cmd 2).
//   rsp_ch : exactly one word per request word, in order, carrying the status
//            and, for reads, the column, element position and merged value.
//   csr_ch : register writes (block edge, column count), always ready; write
//            only while no request word is outstanding.
// Flow
//   The response register loads from the result stage. A word for a column
//   already present passes marker read, block read-modify-write and result;
//   a new column or a dropped element, marker read and result; a read, the
//   read stage and result; a bad word or an empty row, result alone. One word
//   is in flight at a time: no word is taken until the last leaves result.
// Reset
//   After reset the column marker memory is swept, one entry per cycle,
//   through all 1024 entries; req_ch.ready stays low during the sweep.
// Stall
//   A held response keeps its word; the next request word is still taken and
//   processed, and waits in the result stage until the response register frees.
// ----------------------------------------------------------------------------
module sparse_block_row_add import sbra_pkg::*; #(
   parameter int unsigned MAX_SLOTS = SBRA_MAX_SLOTS
) (
   input logic         clock,
   input logic         reset,
   sbra_req_if.sink    req_ch,
   sbra_rsp_if.source  rsp_ch,
   sbra_csr_if.sink    csr_ch
);

   localparam int unsigned SLOT_W   = $clog2(MAX_SLOTS);
   localparam int unsigned USED_W   = SLOT_W + 1;
   localparam int unsigned STORE_AW = SLOT_W + ELEM_W;
   localparam int unsigned VW       = SBRA_VALUE_WIDTH;

   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] slot;
   } marker_type;

   typedef struct packed {
      logic [COL_W-1:0]           column;
      logic [SBRA_SLOT_ELEMS-1:0] mask;
   } slot_entry_type;

   marker_type                  mk_mem [SBRA_MAX_COLUMNS];
   slot_entry_type              sl_mem [MAX_SLOTS];
   logic signed [VW-1:0]        st_mem [MAX_SLOTS * SBRA_SLOT_ELEMS];

   marker_type                  mk_rdata_ff;
   slot_entry_type              sl_rdata_ff;
   logic signed [VW-1:0]        st_rdata_ff;

   logic                        mk_we;
   logic [COL_W-1:0]            mk_waddr, mk_raddr;
   marker_type                  mk_wdata;
   logic                        sl_we;
   logic [SLOT_W-1:0]           sl_waddr, sl_raddr;
   slot_entry_type              sl_wdata;
   logic                        st_we;
   logic [STORE_AW-1:0]         st_waddr, st_raddr;
   logic signed [VW-1:0]        st_wdata;

   state_type                   state_ff, state_in;
   phase_type                   phase_ff, phase_in;
   logic [USED_W-1:0]           slots_used_ff, slots_used_in;
   logic [SLOT_W-1:0]           read_slot_ff, read_slot_in;
   logic [ELEM_W-1:0]           read_elem_ff, read_elem_in;
   logic [COL_W-1:0]            clr_ff, clr_in;
   logic [EDGE_W-1:0]           block_edge_ff;
   logic [COUNT_W-1:0]          column_count_ff;

   logic [COL_W-1:0]            col_ff, col_in;
   logic [ELEM_W-1:0]           el_ff, el_in;
   logic signed [VW-1:0]        value_ff, value_in;
   logic [SLOT_W-1:0]           slot_ff, slot_in;
   rsp_word_type                res_ff, res_in;
   rsp_word_type                rsp_word_ff, rsp_word_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic [EDGE_W-1:0]           edge_eff;
   logic [BNNZ_W-1:0]           bnnz;
   logic [COUNT_W-1:0]          columns_eff;
   logic                        order_ok, index_ok;
   logic [SBRA_SLOT_ELEMS-1:0]  elem_bit;
   cmd_type                     req_cmd;

   always_comb begin
      if (block_edge_ff == '0) begin
         edge_eff = EDGE_W'(1);
      end else if (block_edge_ff > EDGE_W'(SBRA_MAX_BLOCK_EDGE)) begin
         edge_eff = EDGE_W'(SBRA_MAX_BLOCK_EDGE);
      end else begin
         edge_eff = block_edge_ff;
      end
      if (column_count_ff == '0) begin
         columns_eff = COUNT_W'(1);
      end else if (column_count_ff > COUNT_W'(SBRA_MAX_COLUMNS)) begin
         columns_eff = COUNT_W'(SBRA_MAX_COLUMNS);
      end else begin
         columns_eff = column_count_ff;
      end
   end

   assign bnnz     = BNNZ_W'(edge_eff) * BNNZ_W'(edge_eff);
   assign req_cmd  = cmd_type'(req_ch.cmd);
   assign order_ok = (phase_ff != PH_READ) && !(req_cmd == CMD_ELEM_A && phase_ff == PH_B);
   assign index_ok = ({1'b0, req_ch.block_column} < columns_eff)
                  && ({1'b0, req_ch.element_index} < bnnz);

   always_comb begin
      elem_bit         = '0;
      elem_bit[el_ff]  = 1'b1;
   end

   // Memories
   always_ff @(posedge clock) begin
      if (mk_we) begin
         mk_mem[mk_waddr] <= mk_wdata;
      end
      mk_rdata_ff <= mk_mem[mk_raddr];
   end

   always_ff @(posedge clock) begin
      if (sl_we) begin
         sl_mem[sl_waddr] <= sl_wdata;
      end
      sl_rdata_ff <= sl_mem[sl_raddr];
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         st_mem[st_waddr] <= st_wdata;
      end
      st_rdata_ff <= st_mem[st_raddr];
   end

   // Register file
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_edge_ff   <= EDGE_W'(1);
         column_count_ff <= COUNT_W'(SBRA_MAX_COLUMNS);
      end else if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            REG_BLOCK_EDGE:   block_edge_ff   <= csr_ch.data[EDGE_W-1:0];
            REG_COLUMN_COUNT: column_count_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         phase_ff      <= PH_A;
         slots_used_ff <= '0;
         read_slot_ff  <= '0;
         read_elem_ff  <= '0;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         slots_used_ff <= slots_used_in;
         read_slot_ff  <= read_slot_in;
         read_elem_ff  <= read_elem_in;
         clr_ff        <= clr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff      <= col_in;
      el_ff       <= el_in;
      value_ff    <= value_in;
      slot_ff     <= slot_in;
      res_ff      <= res_in;
      rsp_word_ff <= rsp_word_in;
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      slots_used_in = slots_used_ff;
      read_slot_in  = read_slot_ff;
      read_elem_in  = read_elem_ff;
      clr_in        = clr_ff;
      col_in        = col_ff;
      el_in         = el_ff;
      value_in      = value_ff;
      slot_in       = slot_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_word_in   = rsp_word_ff;
      req_ch.ready  = 1'b0;

      mk_we    = 1'b0;
      mk_waddr = col_ff;
      mk_wdata = '0;
      mk_raddr = col_ff;
      sl_we    = 1'b0;
      sl_waddr = slot_ff;
      sl_wdata = '0;
      sl_raddr = slot_ff;
      st_we    = 1'b0;
      st_waddr = {slot_ff, el_ff};
      st_wdata = value_ff;
      st_raddr = {slot_ff, el_ff};

      case (state_ff)
         S_CLEAR: begin
            mk_we    = 1'b1;
            mk_waddr = clr_ff;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == COL_W'(SBRA_MAX_COLUMNS - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            req_ch.ready = 1'b1;
            mk_raddr     = req_ch.block_column;
            sl_raddr     = read_slot_ff;
            st_raddr     = {read_slot_ff, read_elem_ff};
            if (req_ch.valid) begin
               col_in        = req_ch.block_column;
               el_in         = req_ch.element_index;
               value_in      = req_ch.element_value;
               res_in        = '0;
               res_in.status = STAT_BAD;
               state_in      = S_RESULT;
               case (req_cmd)
                  CMD_ELEM_A, CMD_ELEM_B: begin
                     if (order_ok && index_ok) begin
                        if (req_cmd == CMD_ELEM_B) begin
                           phase_in = PH_B;
                        end
                        state_in = S_LOOKUP;
                     end
                  end
                  CMD_READ: begin
                     if (slots_used_ff == '0) begin
                        res_in.status = STAT_ROW_EMPTY;
                        res_in.last   = 1'b1;
                        slots_used_in = '0;
                        read_slot_in  = '0;
                        read_elem_in  = '0;
                        phase_in      = PH_A;
                     end else begin
                        phase_in = PH_READ;
                        state_in = S_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end

         S_LOOKUP: begin
            if (mk_rdata_ff.valid) begin
               slot_in  = mk_rdata_ff.slot;
               sl_raddr = mk_rdata_ff.slot;
               st_raddr = {mk_rdata_ff.slot, el_ff};
               state_in = S_MERGE;
            end else if (slots_used_ff == USED_W'(MAX_SLOTS)) begin
               res_in.status = STAT_SLOTS_FULL;
               state_in      = S_RESULT;
            end else begin
               mk_we         = 1'b1;
               mk_wdata      = '{valid: 1'b1, slot: slots_used_ff[SLOT_W-1:0]};
               sl_we         = 1'b1;
               sl_waddr      = slots_used_ff[SLOT_W-1:0];
               sl_wdata      = '{column: col_ff, mask: elem_bit};
               st_we         = 1'b1;
               st_waddr      = {slots_used_ff[SLOT_W-1:0], el_ff};
               slots_used_in = slots_used_ff + 1'b1;
               res_in.status = STAT_ACCEPTED;
               state_in      = S_RESULT;
            end
         end

         S_MERGE: begin
            st_we    = 1'b1;
            st_wdata = sl_rdata_ff.mask[el_ff] ? sat_add(st_rdata_ff, value_ff) : value_ff;
            sl_we    = 1'b1;
            sl_wdata = '{column: sl_rdata_ff.column, mask: sl_rdata_ff.mask | elem_bit};
            res_in.status = STAT_ACCEPTED;
            state_in      = S_RESULT;
         end

         S_READ: begin
            res_in.status  = STAT_READ_DATA;
            res_in.column  = sl_rdata_ff.column;
            res_in.element = read_elem_ff;
            res_in.value   = sl_rdata_ff.mask[read_elem_ff] ? st_rdata_ff : '0;
            if (BNNZ_W'({1'b0, read_elem_ff} + 1'b1) >= bnnz) begin
               mk_we        = 1'b1;
               mk_waddr     = sl_rdata_ff.column;
               read_elem_in = '0;
               if (USED_W'({1'b0, read_slot_ff} + 1'b1) >= slots_used_ff) begin
                  res_in.last   = 1'b1;
                  slots_used_in = '0;
                  read_slot_in  = '0;
                  phase_in      = PH_A;
               end else begin
                  read_slot_in = read_slot_ff + 1'b1;
               end
            end else begin
               read_elem_in = read_elem_ff + 1'b1;
            end
            state_in = S_RESULT;
         end

         S_RESULT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = res_ff;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_word_ff.status;
   assign rsp_ch.out_column  = rsp_word_ff.column;
   assign rsp_ch.out_element = rsp_word_ff.element;
   assign rsp_ch.out_value   = rsp_word_ff.value;
   assign rsp_ch.row_last    = rsp_word_ff.last;

endmodule

// ===== hw/rtl/sbra_checker.sv =====
// ----------------------------------------------------------------------------
// sbra_checker: port-level checks of the sparse block row adder
// Response stall, reset and field rules seen on the channel ports.
// ----------------------------------------------------------------------------
module sbra_checker import sbra_pkg::*; (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [STATUS_W-1:0]                rsp_status,
   input logic [COL_W-1:0]                   rsp_out_column,
   input logic [ELEM_W-1:0]                  rsp_out_element,
   input logic signed [SBRA_VALUE_WIDTH-1:0] rsp_out_value,
   input logic                               rsp_row_last
);

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("response or request ready active after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable({rsp_status, rsp_out_column, rsp_out_element, rsp_out_value,
                     rsp_row_last}))
      else $error("stalled response word changed");

   a_empty_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_ROW_EMPTY |->
         rsp_row_last && rsp_out_column == '0 && rsp_out_element == '0
         && rsp_out_value == '0)
      else $error("empty row word malformed");

   a_last_on_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_row_last |->
         rsp_status == STAT_READ_DATA || rsp_status == STAT_ROW_EMPTY)
      else $error("row end flagged on a non-read word");

   a_plain_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_ACCEPTED || rsp_status == STAT_SLOTS_FULL
                    || rsp_status == STAT_BAD) |->
         rsp_out_column == '0 && rsp_out_element == '0 && rsp_out_value == '0)
      else $error("non-read word carries data");

endmodule

bind sparse_block_row_add sbra_checker u_sbra_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_status      (rsp_ch.status),
   .rsp_out_column  (rsp_ch.out_column),
   .rsp_out_element (rsp_ch.out_element),
   .rsp_out_value   (rsp_ch.out_value),
   .rsp_row_last    (rsp_ch.row_last)
);

// ===== sim/sparse_block_row_add_tb.sv =====
// ----------------------------------------------------------------------------
// sparse_block_row_add_tb: self-checking bench of the sparse block row adder
// A short table of directed words, then random rows of A and B elements
// followed by reads, under four patterns of source idling and sink stalls.
// Every response word is compared with a behavioural predictor of the merge, or, on checked table rows, with the table.
// ----------------------------------------------------------------------------
module sparse_block_row_add_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sbra_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int SETTLE_CYCLES   = 10;
   localparam int ITEMS_PER_PHASE = 350;

   typedef enum logic {ROW_WORD, ROW_REG} row_kind_type;

   typedef struct packed {
      logic [CMD_W-1:0]            cmd;
      logic [COL_W-1:0]            col;
      logic [ELEM_W-1:0]           elem;
      logic signed [SBRA_VALUE_WIDTH-1:0] val;
   } elem_word_type;

   // register rows: op carries the register index, val the write data
   typedef struct packed {
      row_kind_type                kind;
      logic [1:0]                  op;
      logic [COL_W-1:0]            col;
      logic [ELEM_W-1:0]           elem;
      logic [31:0]                 val;
      logic                        chk;
      status_type                  exp_status;
      logic [COL_W-1:0]            exp_col;
      logic [31:0]                 exp_val;
      logic                        exp_last;
   } plan_row_type;

   localparam plan_row_type PLAN [29] = '{
      '{ROW_WORD, CMD_READ,    10'd1023, 4'd15, 32'hFFFF_FFFF, 1, STAT_ROW_EMPTY, 10'd0, 0, 1},
      '{ROW_WORD, CMD_UNKNOWN, 10'd517,  4'd9,  32'h5A5A_A5A5, 1, STAT_BAD, 10'd0, 0, 0},
      '{ROW_WORD, CMD_ELEM_A,  10'd0,    4'd0,  32'h7FFF_FFFF, 1, STAT_ACCEPTED, 10'd0, 0, 0},
      '{ROW_WORD, CMD_ELEM_A,  10'd1023, 4'd0,  32'h8000_0000, 1, STAT_ACCEPTED, 10'd0, 0, 0},
      '{ROW_WORD, CMD_ELEM_A,  10'd5,    4'd1,  32'h0000_1000, 1, STAT_BAD, 10'd0, 0, 0},
      '{ROW_WORD, CMD_ELEM_B,  10'd0,    4'd0,  32'h0000_0001, 1, STAT_ACCEPTED, 10'd0, 0, 0},
      '{ROW_WORD, CMD_ELEM_A,  10'd7,    4'd0,  32'h0000_0002, 1, STAT_BAD, 10'd0, 0, 0},
      '{ROW_WORD, CMD_ELEM_B,  10'd1023, 4'd0,  32'hFFFF_FFFF, 1, STAT_ACCEPTED, 10'd0, 0, 0},
      '{ROW_WORD, CMD_ELEM_B,  10'd9,    4'd0,  32'h0001_8000, 1, STAT_ACCEPTED, 10'd0, 0, 0},
      '{ROW_WORD, CMD_READ,    10'd0,    4'd0,  32'h0, 1, STAT_READ_DATA, 10'd0, 32'h7FFF_FFFF, 0},
      '{ROW_WORD, CMD_ELEM_A,  10'd3,    4'd0,  32'h0, 1, STAT_BAD, 10'd0, 0, 0},
      '{ROW_WORD, CMD_READ,    10'd0,    4'd0,  32'h0, 1, STAT_READ_DATA, 10'd1023, 32'h8000_0000, 0},
      '{ROW_WORD, CMD_READ,    10'd0,    4'd0,  32'h0, 1, STAT_READ_DATA, 10'd9, 32'h0001_8000, 1},
      '{ROW_REG,  REG_BLOCK_EDGE,   10'd0, 4'd0, 32'd7, 0, STAT_ACCEPTED, 10'd0, 0, 0},
      '{ROW_REG,  REG_COLUMN_COUNT, 10'd0, 4'd0, 32'd0, 0, STAT_ACCEPTED, 10'd0, 0, 0},
      '{ROW_WORD, CMD_ELEM_A,  10'd1,    4'd0,  32'h0001_0000, 1, STAT_BAD, 10'd0, 0, 0},
      '{ROW_WORD, CMD_ELEM_A,  10'd0,    4'd15, 32'h1234_5678, 0, STAT_ACCEPTED, 10'd0, 0, 0},
      '{ROW_WORD, CMD_ELEM_B,  10'd0,    4'd15, 32'h0FFF_0000, 0, STAT_ACCEPTED, 10'd0, 0, 0},
      '{ROW_WORD, CMD_ELEM_B,  10'd0,    4'd3,  32'hFFFF_FFFB, 0, STAT_ACCEPTED, 10'd0, 0, 0},
      '{ROW_WORD, CMD_READ,    10'd0,    4'd0,  32'h0, 0, STAT_ACCEPTED, 10'd0, 0, 0},
      '{ROW_REG,  REG_BLOCK_EDGE,   10'd0, 4'd0, 32'd2, 0, STAT_ACCEPTED, 10'd0, 0, 0},
      '{ROW_WORD, CMD_READ,    10'd0,    4'd0,  32'h0, 0, STAT_ACCEPTED, 10'd0, 0, 0},
      '{ROW_WORD, CMD_READ,    10'd0,    4'd0,  32'h0, 0, STAT_ACCEPTED, 10'd0, 0, 0},
      '{ROW_WORD, CMD_READ,    10'd0,    4'd0,  32'h0, 0, STAT_ACCEPTED, 10'd0, 0, 0},
      '{ROW_REG,  REG_BLOCK_EDGE,   10'd0, 4'd0, 32'd0, 0, STAT_ACCEPTED, 10'd0, 0, 0},
      '{ROW_REG,  REG_COLUMN_COUNT, 10'd0, 4'd0, 32'd2047, 0, STAT_ACCEPTED, 10'd0, 0, 0},
      '{ROW_WORD, CMD_ELEM_A,  10'd1023, 4'd0,  32'h0001_0000, 0, STAT_ACCEPTED, 10'd0, 0, 0},
      '{ROW_WORD, CMD_READ,    10'd0,    4'd0,  32'h0, 0, STAT_ACCEPTED, 10'd0, 0, 0},
      '{ROW_WORD, CMD_READ,    10'd0,    4'd0,  32'h0, 1, STAT_ROW_EMPTY, 10'd0, 0, 1}
   };

   logic clock = 1'b0;
   logic reset;

   sbra_req_if req_ch ();
   sbra_rsp_if rsp_ch ();
   sbra_csr_if csr_ch ();

   logic         req_chk;
   rsp_word_type req_exp;

   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int items_sent    = 0;
   int fail_count    = 0;
   int stall_cycles  = 0;

   rsp_word_type merged_expect [$];

   // merge state
   logic [EDGE_W-1:0]  cfg_edge = 3'd1;
   logic [COUNT_W-1:0] cfg_cols = 11'd1024;
   bit                 col_present [SBRA_MAX_COLUMNS];
   int                 col_slot [SBRA_MAX_COLUMNS];
   logic [COL_W-1:0]   slot_col [SBRA_MAX_SLOTS];
   logic signed [SBRA_VALUE_WIDTH-1:0] blk_val [SBRA_MAX_SLOTS][SBRA_SLOT_ELEMS];
   int                 slot_count = 0;
   int                 rd_slot    = 0;
   int                 rd_elem    = 0;
   phase_type          row_phase  = PH_A;

   sparse_block_row_add i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #10 clock = ~clock;

   function automatic int eff_edge();
      if (cfg_edge == 0) return 1;
      if (cfg_edge > SBRA_MAX_BLOCK_EDGE) return SBRA_MAX_BLOCK_EDGE;
      return int'(cfg_edge);
   endfunction

   function automatic int eff_cols();
      if (cfg_cols == 0) return 1;
      if (cfg_cols > SBRA_MAX_COLUMNS) return SBRA_MAX_COLUMNS;
      return int'(cfg_cols);
   endfunction

   function automatic logic signed [SBRA_VALUE_WIDTH-1:0] sat_sum(
      input logic signed [SBRA_VALUE_WIDTH-1:0] a,
      input logic signed [SBRA_VALUE_WIDTH-1:0] b
   );
      longint s;
      s = longint'(a) + longint'(b);
      if (s > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (s < -64'sd2147483648) return 32'sh8000_0000;
      return s[SBRA_VALUE_WIDTH-1:0];
   endfunction

   function automatic void close_row();
      slot_count = 0;
      rd_slot    = 0;
      rd_elem    = 0;
      row_phase  = PH_A;
   endfunction

   function automatic rsp_word_type merge_predict(input elem_word_type w);
      rsp_word_type r;
      int           bnnz;
      int           s;
      int           e;
      bit           order_ok;
      r = '0;
      r.status = STAT_BAD;
      bnnz = eff_edge() * eff_edge();
      case (w.cmd)
         CMD_ELEM_A, CMD_ELEM_B: begin
            order_ok = row_phase != PH_READ && !(w.cmd == CMD_ELEM_A && row_phase == PH_B);
            if (order_ok && int'(w.col) < eff_cols() && int'(w.elem) < bnnz) begin
               if (w.cmd == CMD_ELEM_B) row_phase = PH_B;
               if (!col_present[w.col] && slot_count >= SBRA_MAX_SLOTS) begin
                  r.status = STAT_SLOTS_FULL;
               end else begin
                  if (!col_present[w.col]) begin
                     s = slot_count;
                     slot_count++;
                     slot_col[s] = w.col;
                     col_slot[w.col] = s;
                     col_present[w.col] = 1'b1;
                     for (int k = 0; k < SBRA_SLOT_ELEMS; k++) blk_val[s][k] = '0;
                  end
                  s = col_slot[w.col];
                  blk_val[s][w.elem] = sat_sum(blk_val[s][w.elem], w.val);
                  r.status = STAT_ACCEPTED;
               end
            end
         end
         CMD_READ: begin
            if (slot_count == 0) begin
               r.status = STAT_ROW_EMPTY;
               r.last = 1'b1;
               close_row();
            end else begin
               s = rd_slot % SBRA_MAX_SLOTS;
               e = rd_elem % SBRA_SLOT_ELEMS;
               row_phase = PH_READ;
               r.status  = STAT_READ_DATA;
               r.column  = slot_col[s];
               r.element = e[ELEM_W-1:0];
               r.value   = blk_val[s][e];
               if (e + 1 >= bnnz) begin
                  col_present[slot_col[s]] = 1'b0;
                  rd_elem = 0;
                  rd_slot++;
                  if (rd_slot >= slot_count) begin
                     r.last = 1'b1;
                     close_row();
                  end
               end else begin
                  rd_elem = e + 1;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // responses, accepted words, register writes and the watchdog
   always @(posedge clock) begin
      rsp_word_type want;
      elem_word_type w;
      logic moved;
      moved = 1'b0;
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         moved = 1'b1;
         if (merged_expect.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) $display("response word with nothing outstanding: status %0d",
                                           rsp_ch.status);
         end else begin
            want = merged_expect.pop_front();
            if (rsp_ch.status !== want.status || rsp_ch.out_column !== want.column ||
                rsp_ch.out_element !== want.element || rsp_ch.out_value !== want.value ||
                rsp_ch.row_last !== want.last) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch: want st %0d col %0d el %0d val %h last %0d, %s",
                           want.status, want.column, want.element, want.value, want.last,
                           $sformatf("got st %0d col %0d el %0d val %h last %0d",
                                     rsp_ch.status, rsp_ch.out_column, rsp_ch.out_element,
                                     rsp_ch.out_value, rsp_ch.row_last));
            end
         end
      end
      if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
         moved = 1'b1;
         w = '{cmd: req_ch.cmd, col: req_ch.block_column, elem: req_ch.element_index,
               val: req_ch.element_value};
         want = merge_predict(w);
         if (req_chk) want = req_exp;
         merged_expect.push_back(want);
      end
      if (csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1) begin
         moved = 1'b1;
         case (csr_ch.index)
            REG_BLOCK_EDGE:   cfg_edge = csr_ch.data[EDGE_W-1:0];
            REG_COLUMN_COUNT: cfg_cols = csr_ch.data[COUNT_W-1:0];
            default: ;
         endcase
      end
      if (moved) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ch.ready <= (rsp_stall_pct == 0) || ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic send_word(input elem_word_type w, input logic chk, input rsp_word_type exp);
      if (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_ch.valid         <= 1'b1;
      req_ch.cmd           <= w.cmd;
      req_ch.block_column  <= w.col;
      req_ch.element_index <= w.elem;
      req_ch.element_value <= w.val;
      req_chk              <= chk;
      req_exp              <= exp;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (merged_expect.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      @(posedge clock);
      while (csr_ch.ready !== 1'b1) @(posedge clock);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // stage 0 loading A, 1 loading B, 2 reading
   task automatic send_noise(input int stage);
      elem_word_type w;
      int bnnz;
      int pick;
      bnnz = eff_edge() * eff_edge();
      w.cmd  = CMD_UNKNOWN;
      w.col  = COL_W'($urandom);
      w.elem = ELEM_W'($urandom);
      w.val  = $urandom;
      pick = $urandom_range(3);
      if (pick == 1 && eff_cols() < SBRA_MAX_COLUMNS) begin
         w.cmd = (stage == 0) ? CMD_ELEM_A : CMD_ELEM_B;
         w.col = COL_W'($urandom_range(SBRA_MAX_COLUMNS - 1, eff_cols()));
      end else if (pick == 2 && bnnz < SBRA_SLOT_ELEMS) begin
         w.cmd  = (stage == 0) ? CMD_ELEM_A : CMD_ELEM_B;
         w.col  = COL_W'($urandom_range(eff_cols() - 1));
         w.elem = ELEM_W'($urandom_range(SBRA_SLOT_ELEMS - 1, bnnz));
      end else if (pick == 3 && stage != 0) begin
         w.cmd  = (stage == 1 || $urandom_range(1) == 0) ? CMD_ELEM_A : CMD_ELEM_B;
         w.col  = COL_W'($urandom_range(eff_cols() - 1));
         w.elem = ELEM_W'($urandom_range(bnnz - 1));
      end
      send_word(w, 1'b0, '0);
   endtask

   task automatic random_row();
      elem_word_type w;
      int  bnnz;
      int  cols;
      int  n_cols;
      int  n_a;
      int  n_b;
      int  full;
      int  reads;
      int  base;
      bit  big;
      int  pool [$];
      bit  seen [int];
      bnnz = eff_edge() * eff_edge();
      cols = eff_cols();
      big  = bnnz == 1 && cols >= 72 && $urandom_range(7) == 0;
      n_cols = big ? $urandom_range(72, 65) : $urandom_range(6, 1);
      base = $urandom_range(cols - 1);
      for (int k = 0; k < n_cols; k++)
         pool.push_back(big ? (base + k) % cols : $urandom_range(cols - 1));
      n_a = big ? n_cols / 2 : $urandom_range(8, 0);
      n_b = big ? n_cols - n_a : $urandom_range(8, 0);
      for (int k = 0; k < n_a + n_b; k++) begin
         if ($urandom_range(19) == 0) send_noise(k > n_a ? 1 : 0);
         w.cmd = (k < n_a) ? CMD_ELEM_A : CMD_ELEM_B;
         if (big) w.col = COL_W'(pool[k]);
         else if (k >= n_a && $urandom_range(3) == 0) w.col = COL_W'($urandom_range(cols - 1));
         else w.col = COL_W'(pool[$urandom_range(n_cols - 1)]);
         w.elem = ELEM_W'($urandom_range(bnnz - 1));
         case ($urandom_range(7))
            0: w.val = 32'sh7FFF_FFFF;
            1: w.val = 32'sh8000_0000;
            2: w.val = {{16{1'b1}}, 16'($urandom)};
            default: w.val = $urandom;
         endcase
         seen[int'(w.col)] = 1'b1;
         send_word(w, 1'b0, '0);
         items_sent++;
      end
      full  = (seen.size() > SBRA_MAX_SLOTS ? SBRA_MAX_SLOTS : seen.size()) * bnnz;
      reads = full;
      if (reads == 0 || $urandom_range(9) == 0) reads++;
      for (int k = 0; k < reads; k++) begin
         if (k > 0 && k < full && $urandom_range(19) == 0) send_noise(2);
         w.cmd  = CMD_READ;
         w.col  = COL_W'($urandom);
         w.elem = ELEM_W'($urandom);
         w.val  = $urandom;
         send_word(w, 1'b0, '0);
         items_sent++;
      end
   endtask

   initial begin
      elem_word_type w;
      rsp_word_type  exp;
      int            target;
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.cmd           = '0;
      req_ch.block_column  = '0;
      req_ch.element_index = '0;
      req_ch.element_value = '0;
      req_chk              = 1'b0;
      req_exp              = '0;
      csr_ch.valid         = 1'b0;
      csr_ch.index         = REG_BLOCK_EDGE;
      csr_ch.data          = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(PLAN); i++) begin
         if (PLAN[i].kind == ROW_REG) begin
            drain();
            write_reg(csr_index_type'(PLAN[i].op), PLAN[i].val[CSR_DATA_W-1:0]);
         end else begin
            w   = '{cmd: PLAN[i].op, col: PLAN[i].col, elem: PLAN[i].elem,
                    val: PLAN[i].val};
            exp = '{status: PLAN[i].exp_status, column: PLAN[i].exp_col, element: '0,
                    value: PLAN[i].exp_val, last: PLAN[i].exp_last};
            send_word(w, PLAN[i].chk, exp);
         end
      end

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 78; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 78; end
            default: begin req_idle_pct = 35; rsp_stall_pct = 35; end
         endcase
         target = items_sent + ITEMS_PER_PHASE;
         while (items_sent < target) begin
            if ($urandom_range(3) == 0) begin
               drain();
               if ($urandom_range(1) == 0) begin
                  case ($urandom_range(5))
                     0: write_reg(REG_BLOCK_EDGE, 11'd0);
                     1: write_reg(REG_BLOCK_EDGE, 11'd1);
                     2: write_reg(REG_BLOCK_EDGE, 11'd4);
                     3: write_reg(REG_BLOCK_EDGE, 11'd7);
                     default: write_reg(REG_BLOCK_EDGE, 11'($urandom_range(7)));
                  endcase
               end
               if ($urandom_range(1) == 0) begin
                  case ($urandom_range(6))
                     0: write_reg(REG_COLUMN_COUNT, 11'd0);
                     1: write_reg(REG_COLUMN_COUNT, 11'd1);
                     2: write_reg(REG_COLUMN_COUNT, 11'd1024);
                     3: write_reg(REG_COLUMN_COUNT, 11'd2047);
                     4: write_reg(REG_COLUMN_COUNT, 11'($urandom_range(100, 2)));
                     default: write_reg(REG_COLUMN_COUNT, 11'($urandom_range(2047, 1)));
                  endcase
               end
            end
            random_row();
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && merged_expect.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
